// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Each macro is empty when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/mcled_pkg.sv =====
package mcled_pkg;

    localparam int CFG_W      = 10;
    localparam int MASK_W     = 8;
    localparam int SLOT_OUT_W = 3;

    localparam logic [CFG_W-1:0] TICK_PERIOD_RESET = 10'd10;

    // Command codes; the start codes double as slot modes.
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] MODE_ONESHOT = 2'd1;
    localparam logic [1:0] MODE_COUNTED = 2'd2;
    localparam logic [1:0] MODE_ENDLESS = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] on_ms;
        logic [23:0] off_ms;
        logic [15:0] blink_count;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  start_accepted;
        logic                  slots_full;
        logic [MASK_W-1:0]     led_write_mask;
        logic [MASK_W-1:0]     led_level;
        logic [MASK_W-1:0]     active_mask;
    } t_out_item;

    typedef struct packed {
        logic       running;
        logic [1:0] mode;
        logic       started;
        logic       lit;
    } t_slot_flags;

    typedef struct packed {
        t_slot_flags flags;
        logic        wr;
        logic        lvl;
    } t_slot_upd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FIN
    } t_state;

endpackage

// ===== src/mcled_ram.sv =====
module mcled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mcled_alu.sv =====
module mcled_alu
    import mcled_pkg::*;
#(
    parameter int TIME_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  t_slot_flags                         i_flags,
    input  logic [4*TIME_BITS+COUNT_BITS-1:0]   i_rec,
    input  logic [CFG_W-1:0]                    i_tick_period,
    output t_slot_upd                           o_upd,
    output logic [4*TIME_BITS+COUNT_BITS-1:0]   o_rec
);

    // Arithmetic width covers both the time values and the tick period.
    localparam int AW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    logic [TIME_BITS-1:0]  on_rel, off_rel, on_rem, off_rem;
    logic [COUNT_BITS-1:0] blinks, blinks_dec;
    logic [AW-1:0]         op_w, tp_w, diff_w;
    logic                  use_on, below;
    logic [TIME_BITS-1:0]  diff;

    assign {on_rel, off_rel, on_rem, off_rem, blinks} = i_rec;

    // The one shared saturating subtract and compare against the tick period.
    assign use_on     = (i_flags.mode == MODE_ONESHOT) || i_flags.lit;
    assign op_w       = use_on ? AW'(on_rem) : AW'(off_rem);
    assign tp_w       = AW'(i_tick_period);
    assign diff_w     = (op_w > tp_w) ? (op_w - tp_w) : '0;
    assign below      = diff_w < tp_w;
    assign diff       = TIME_BITS'(diff_w);
    assign blinks_dec = blinks - COUNT_BITS'(1);

    always_comb begin
        logic [TIME_BITS-1:0]  n_on_rem, n_off_rem;
        logic [COUNT_BITS-1:0] n_blinks;
        n_on_rem  = on_rem;
        n_off_rem = off_rem;
        n_blinks  = blinks;
        o_upd.flags = i_flags;
        o_upd.wr    = 1'b0;
        o_upd.lvl   = 1'b0;
        if (i_flags.running) begin
            if (!i_flags.started) begin
                o_upd.flags.started = 1'b1;
                o_upd.flags.lit     = 1'b1;
                o_upd.wr            = 1'b1;
                o_upd.lvl           = 1'b1;
            end else if (i_flags.mode == MODE_ONESHOT) begin
                n_on_rem = diff;
                if (below) begin
                    o_upd.wr            = 1'b1;
                    o_upd.flags.lit     = 1'b0;
                    o_upd.flags.running = 1'b0;
                end
            end else if (i_flags.lit) begin
                n_on_rem = diff;
                if (below) begin
                    o_upd.wr        = 1'b1;
                    o_upd.flags.lit = 1'b0;
                    if (i_flags.mode == MODE_COUNTED) begin
                        n_blinks = blinks_dec;
                        if (blinks_dec == '0) begin
                            o_upd.flags.running = 1'b0;
                        end else begin
                            n_on_rem = on_rel;
                        end
                    end else begin
                        n_on_rem = on_rel;
                    end
                end
            end else begin
                n_off_rem = diff;
                if (below) begin
                    o_upd.wr        = 1'b1;
                    o_upd.lvl       = 1'b1;
                    o_upd.flags.lit = 1'b1;
                    n_off_rem       = off_rel;
                end
            end
        end
        o_rec = {on_rel, off_rel, n_on_rem, n_off_rem, n_blinks};
    end

endmodule

// ===== src/multi_channel_led_blink_controller_top.sv =====
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_ready   i_in_item  (t_in_item)
// output    o_out_valid / i_out_ready o_out_item (t_out_item)
// config    i_cfg_we (no wait)        i_cfg_wdata (tick period in ms)
//
// A start item claims its slot at the accepting edge, and the result is loaded into the
// output register in ST_FIN once that register is free.
// A tick item is accepted in idle; the sequencer then walks the slot RAM through the
// shared update unit, reading one slot while the previous one is written back, and
// then loads the result. Reset clears the slot flags and sets the tick period to
// 10 ms; the RAM needs no clearing since every start writes the whole record.
// A result that waits on i_out_ready stalls only the final load; the next item
// is accepted as soon as the sequencer is back in idle.
`include "assert_macros.svh"

module multi_channel_led_blink_controller_top
    import mcled_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int TIME_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int REC_W = 4 * TIME_BITS + COUNT_BITS;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_tick_period;
    t_slot_flags          r_flags [CHANNELS];
    logic [CNT_W-1:0]     r_rd_cnt, n_rd_cnt;
    logic                 r_ex_valid, n_ex_valid;
    logic [IDX_W-1:0]     r_ex_idx, n_ex_idx;
    logic [CHANNELS-1:0]  r_wmask, r_level;
    logic [IDX_W-1:0]     r_res_idx;
    logic                 r_res_acc, r_res_full;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic                 accept, is_start, load_out;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic [CHANNELS-1:0]  running_bits;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [REC_W-1:0]     ram_wdata, ram_rdata, start_rec, alu_rec;

    logic [TIME_BITS-1:0]  st_on, st_off;
    logic [COUNT_BITS-1:0] st_cnt, st_blinks;

    t_slot_upd            alu_upd;

    assign accept   = i_in_valid && o_in_ready;
    assign is_start = i_in_item.cmd != CMD_TICK;

    // Lowest free slot, taken by a start command.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (!r_flags[c].running) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(c);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            running_bits[c] = r_flags[c].running;
        end
    end

    // Record written by a start: on and off times are loaded as both reload and
    // remaining value. A one-shot has no off phase, and only a counted blink
    // carries a count, with zero standing for one.
    assign st_on     = TIME_BITS'(i_in_item.on_ms);
    assign st_off    = (i_in_item.cmd == MODE_ONESHOT) ? '0 : TIME_BITS'(i_in_item.off_ms);
    assign st_cnt    = COUNT_BITS'(i_in_item.blink_count);
    assign st_blinks = (i_in_item.cmd != MODE_COUNTED) ? '0 :
                       (st_cnt == '0) ? COUNT_BITS'(1) : st_cnt;
    assign start_rec = {st_on, st_off, st_on, st_off, st_blinks};

    // The RAM is written either by a start at the accepting edge or by the
    // write-back of the slot in the update stage.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ex_idx;
        ram_wdata = alu_rec;
        if (r_state == ST_IDLE) begin
            ram_we    = accept && is_start && free_found;
            ram_waddr = free_idx;
            ram_wdata = start_rec;
        end else if (r_state == ST_TICK) begin
            ram_we = r_ex_valid;
        end
    end

    assign ram_raddr = r_rd_cnt[IDX_W-1:0];

    mcled_ram #(
        .WIDTH(REC_W),
        .DEPTH(CHANNELS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    mcled_alu #(
        .TIME_BITS (TIME_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_alu (
        .i_flags      (r_flags[r_ex_idx]),
        .i_rec        (ram_rdata),
        .i_tick_period(r_tick_period),
        .o_upd        (alu_upd),
        .o_rec        (alu_rec)
    );

    // Sequencer: next state, read counter and update-stage valid.
    always_comb begin
        n_state    = r_state;
        n_rd_cnt   = r_rd_cnt;
        n_ex_valid = 1'b0;
        n_ex_idx   = r_ex_idx;
        load_out   = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_rd_cnt   = '0;
                if (accept) begin
                    n_state = is_start ? ST_FIN : ST_TICK;
                end
            end
            ST_TICK: begin
                if (r_rd_cnt < CNT_W'(CHANNELS)) begin
                    n_ex_valid = 1'b1;
                    n_ex_idx   = r_rd_cnt[IDX_W-1:0];
                    n_rd_cnt   = r_rd_cnt + CNT_W'(1);
                end else if (!r_ex_valid) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_rd_cnt      <= '0;
            r_ex_valid    <= 1'b0;
            r_ex_idx      <= '0;
            r_tick_period <= TICK_PERIOD_RESET;
            r_out_valid   <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_flags[c] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_rd_cnt   <= n_rd_cnt;
            r_ex_valid <= n_ex_valid;
            r_ex_idx   <= n_ex_idx;
            if (i_cfg_we) begin
                r_tick_period <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_IDLE && accept && is_start && free_found) begin
                r_flags[free_idx] <= '{running: 1'b1, mode: i_in_item.cmd,
                                       started: 1'b0, lit: 1'b0};
            end else if (r_state == ST_TICK && r_ex_valid) begin
                r_flags[r_ex_idx] <= alu_upd.flags;
            end
        end
    end

    // Result fields collected over the item; the LED masks build up one slot at a time.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept) begin
            r_wmask    <= '0;
            r_level    <= '0;
            r_res_idx  <= (is_start && free_found) ? free_idx : '0;
            r_res_acc  <= is_start && free_found;
            r_res_full <= is_start && !free_found;
        end else if (r_state == ST_TICK && r_ex_valid) begin
            r_wmask[r_ex_idx] <= alu_upd.wr;
            r_level[r_ex_idx] <= alu_upd.lvl;
        end
        if (load_out) begin
            r_out.slot_index     <= SLOT_OUT_W'(r_res_idx);
            r_out.start_accepted <= r_res_acc;
            r_out.slots_full     <= r_res_full;
            r_out.led_write_mask <= MASK_W'(r_wmask);
            r_out.led_level      <= MASK_W'(r_level);
            r_out.active_mask    <= MASK_W'(running_bits);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The update stage only runs while the sequencer walks the slots.
    `ASSERT_SAME(a_ex_in_tick, i_clk, i_rst_n, r_ex_valid, r_state == ST_TICK)
    // A start result never reports both a claimed slot and a full table.
    `ASSERT_SAME(a_acc_full_excl, i_clk, i_rst_n, r_out_valid,
                 !(r_out.start_accepted && r_out.slots_full))
    // A level bit is only reported for an LED that was written.
    `ASSERT_SAME(a_level_in_mask, i_clk, i_rst_n, r_out_valid,
                 (r_out.led_level & ~r_out.led_write_mask) == '0)
    // A start item goes straight to the result stage.
    `ASSERT_NEXT(a_start_to_fin, i_clk, i_rst_n, accept && is_start, r_state == ST_FIN)

endmodule

// ===== sim/mcled_checker.sv =====
module mcled_checker
    import mcled_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_item         i_in_item,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_item        i_out_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output int               o_mismatches,
    output int               o_outstanding
);

    localparam int CHANNELS = 8;

    // Shadow copy of the channel slots and the tick period.
    logic [CFG_W-1:0] period_ms;
    logic             ch_busy      [CHANNELS];
    logic [1:0]       ch_mode      [CHANNELS];
    logic             ch_primed    [CHANNELS];
    logic             ch_lit       [CHANNELS];
    logic [23:0]      on_load      [CHANNELS];
    logic [23:0]      off_load     [CHANNELS];
    logic [23:0]      on_left      [CHANNELS];
    logic [23:0]      off_left     [CHANNELS];
    logic [15:0]      blinks_to_go [CHANNELS];

    t_out_item expected_results [$];
    t_out_item want;
    int        mismatches  = 0;
    int        outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    // One tick takes the period off a remaining time, stopping at zero.
    function automatic logic [23:0] drain_time(input logic [23:0] left);
        return (left > 24'(period_ms)) ? left - 24'(period_ms) : '0;
    endfunction

    // Applies one item to the shadow slots and returns the result it causes.
    task automatic step_channels(input t_in_item it, output t_out_item res);
        logic claimed;
        claimed = 1'b0;
        res = '0;
        if (it.cmd != CMD_TICK) begin
            res.slots_full = 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
                if (!ch_busy[c] && !claimed) begin
                    claimed         = 1'b1;
                    ch_busy[c]      = 1'b1;
                    ch_mode[c]      = it.cmd;
                    ch_primed[c]    = 1'b0;
                    ch_lit[c]       = 1'b0;
                    on_load[c]      = it.on_ms;
                    on_left[c]      = it.on_ms;
                    off_load[c]     = (it.cmd == MODE_ONESHOT) ? '0 : it.off_ms;
                    off_left[c]     = off_load[c];
                    blinks_to_go[c] = '0;
                    if (it.cmd == MODE_COUNTED) begin
                        blinks_to_go[c] = (it.blink_count == '0) ? 16'd1 : it.blink_count;
                    end
                    res.slot_index     = SLOT_OUT_W'(c);
                    res.start_accepted = 1'b1;
                    res.slots_full     = 1'b0;
                end
            end
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (!ch_busy[c]) begin
                    continue;
                end
                if (!ch_primed[c]) begin
                    ch_primed[c]          = 1'b1;
                    ch_lit[c]             = 1'b1;
                    res.led_write_mask[c] = 1'b1;
                    res.led_level[c]      = 1'b1;
                end else if (ch_mode[c] == MODE_ONESHOT) begin
                    on_left[c] = drain_time(on_left[c]);
                    if (on_left[c] < 24'(period_ms)) begin
                        res.led_write_mask[c] = 1'b1;
                        ch_lit[c]             = 1'b0;
                        ch_busy[c]            = 1'b0;
                    end
                end else if (ch_lit[c]) begin
                    on_left[c] = drain_time(on_left[c]);
                    if (on_left[c] < 24'(period_ms)) begin
                        res.led_write_mask[c] = 1'b1;
                        ch_lit[c]             = 1'b0;
                        if (ch_mode[c] == MODE_COUNTED) begin
                            blinks_to_go[c] = blinks_to_go[c] - 16'd1;
                            if (blinks_to_go[c] == '0) begin
                                ch_busy[c] = 1'b0;
                            end
                        end
                        if (ch_busy[c]) begin
                            on_left[c] = on_load[c];
                        end
                    end
                end else begin
                    off_left[c] = drain_time(off_left[c]);
                    if (off_left[c] < 24'(period_ms)) begin
                        res.led_write_mask[c] = 1'b1;
                        res.led_level[c]      = 1'b1;
                        ch_lit[c]             = 1'b1;
                        off_left[c]           = off_load[c];
                    end
                end
            end
        end
        for (int c = 0; c < CHANNELS; c++) begin
            res.active_mask[c] = ch_busy[c];
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period_ms = TICK_PERIOD_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                ch_busy[c]   = 1'b0;
                ch_mode[c]   = CMD_TICK;
                ch_primed[c] = 1'b0;
                ch_lit[c]    = 1'b0;
            end
            expected_results.delete();
        end else begin
            // Results are retired before new items are predicted, since a result
            // leaving at this edge always belongs to an earlier item.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: slot=%0d acc=%0b full=%0b wr=%02h lvl=%02h act=%02h",
                                 i_out_item.slot_index, i_out_item.start_accepted,
                                 i_out_item.slots_full, i_out_item.led_write_mask,
                                 i_out_item.led_level, i_out_item.active_mask);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.slot_index !== want.slot_index
                        || i_out_item.start_accepted !== want.start_accepted
                        || i_out_item.slots_full !== want.slots_full
                        || i_out_item.led_write_mask !== want.led_write_mask
                        || i_out_item.led_level !== want.led_level
                        || i_out_item.active_mask !== want.active_mask) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected slot=%0d acc=%0b full=%0b wr=%02h lvl=%02h act=%02h",
                                     want.slot_index, want.start_accepted, want.slots_full,
                                     want.led_write_mask, want.led_level, want.active_mask);
                            $display("          actual   slot=%0d acc=%0b full=%0b wr=%02h lvl=%02h act=%02h",
                                     i_out_item.slot_index, i_out_item.start_accepted,
                                     i_out_item.slots_full, i_out_item.led_write_mask,
                                     i_out_item.led_level, i_out_item.active_mask);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                period_ms = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                step_channels(i_in_item, want);
                expected_results.push_back(want);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    import mcled_pkg::*;

    // A tick item walks all eight slots, one per cycle, besides accepting the item and loading its result.
    // Without a receiver stall this is the longest the block can be busy with a single item.
    localparam int ITEM_CYCLES = 8 + 4;
    // Length of the single long receiver hold-off, in cycles.
    localparam int LONG_HOLD = 400;

    // Which side inserts idle cycles during the current stretch of items.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_item         in_item   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_item;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    int               mismatches;
    int               outstanding;

    // The stimulus keeps its own copy of the tick period so that random on and
    // off times can be chosen near it, which is where the channels toggle often.
    logic [CFG_W-1:0] tick_ms       = TICK_PERIOD_RESET;
    t_idle            idle_mode     = IDLE_NONE;
    int               hold_requests = 0;
    int               holds_granted = 0;
    int               hold_left     = 0;
    int               stall_pct;

    always #4 clk = ~clk;

    multi_channel_led_blink_controller_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // The checker watches both channels and the register port, predicts every
    // result and compares; this module only drives stimulus and decides.
    mcled_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // The receiver decides its ready at each falling edge. A pending hold-off
    // request wins over everything else and holds ready low until hold_left runs out,
    // while the sender keeps offering items, so the block backs up and stalls.
    always @(negedge clk) begin
        if (holds_granted != hold_requests) begin
            holds_granted = hold_requests;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 56 : (idle_mode == IDLE_BOTH) ? 35 : 0;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic t_in_item make_item(input logic [1:0] cmd, input logic [23:0] on_ms,
                                           input logic [23:0] off_ms,
                                           input logic [15:0] blink_count);
        t_in_item it;
        it.cmd         = cmd;
        it.on_ms       = on_ms;
        it.off_ms      = off_ms;
        it.blink_count = blink_count;
        return it;
    endfunction

    // A time of up to about four tick periods, so a phase lasts a few ticks at most.
    function automatic logic [23:0] near_period();
        return 24'($urandom_range(0, 4 * int'(tick_ms) + 3));
    endfunction

    // Ticks carry random noise in the fields they ignore. Starts mostly get short
    // times and small blink counts so that slots keep freeing up. With wide set,
    // full-width values and endless blinks also appear; those hold their slot
    // for a very long time or for good, so they are kept to the late phases.
    function automatic t_in_item random_item(input bit wide);
        t_in_item    it;
        int unsigned roll;
        it.on_ms       = 24'($urandom);
        it.off_ms      = 24'($urandom);
        it.blink_count = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 58) begin
            it.cmd = CMD_TICK;
        end else begin
            if (roll < 74) begin
                it.cmd = MODE_ONESHOT;
            end else if (roll < 95 || !wide) begin
                it.cmd = MODE_COUNTED;
            end else begin
                it.cmd = MODE_ENDLESS;
            end
            if (!wide || $urandom_range(0, 15) != 0) begin
                it.on_ms = near_period();
            end
            if (!wide || $urandom_range(0, 15) != 0) begin
                it.off_ms = near_period();
            end
            if (!wide || $urandom_range(0, 15) != 0) begin
                it.blink_count = 16'($urandom_range(0, 4));
            end
        end
        return it;
    endfunction

    // Offers one item, idling first with the sender's current odds, and holds it
    // until accepted. It returns at the falling edge after the accepting edge
    // without touching any input there, so the caller may drive the next item.
    task automatic send_item(input t_in_item it);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 56 : (idle_mode == IDLE_BOTH) ? 35 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do begin
            @(posedge clk);
        end while (!in_ready);
        @(negedge clk);
    endtask

    // The register is only written while the block is idle: every expected
    // result has come back, and a full item time has passed on top of that.
    task automatic set_tick_period(input logic [CFG_W-1:0] ms);
        in_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (ITEM_CYCLES + 2) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ms;
        @(negedge clk);
        cfg_we  <= 1'b0;
        tick_ms = ms;
    endtask

    // The idling style rotates every 40 items, so every phase of the block's
    // work sees gaps on each side as well as stretches with none.
    task automatic run_phase(input int count, input bit wide);
        for (int n = 0; n < count; n++) begin
            idle_mode = t_idle'((n / 40) % 4);
            send_item(random_item(wide));
        end
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with the tick period at its reset value of 10 ms.
        // A tick with no running slot, carrying all-ones noise in its fields.
        send_item(make_item(CMD_TICK, '1, '1, '1));
        // One-shot with zero on time; its off time and count must be ignored.
        send_item(make_item(MODE_ONESHOT, 24'd0, '1, '1));
        // Counted blink with a count of zero, which behaves as a single blink.
        send_item(make_item(MODE_COUNTED, 24'd5, 24'd0, 16'd0));
        send_item(make_item(MODE_COUNTED, 24'd25, 24'd15, 16'd2));
        // Endless blink with zero times toggles on every tick from now on.
        send_item(make_item(MODE_ENDLESS, 24'd0, 24'd0, '1));
        // One-shots right at, just under and well above the tick period, with a counted blink among them.
        send_item(make_item(MODE_ONESHOT, 24'd10, 24'd0, 16'd0));
        send_item(make_item(MODE_ONESHOT, 24'd9, 24'd0, 16'd0));
        send_item(make_item(MODE_COUNTED, 24'd30, 24'd30, 16'd1));
        send_item(make_item(MODE_ONESHOT, 24'd100, 24'd0, 16'd0));
        // All eight slots are now taken, so these two starts must be refused.
        send_item(make_item(MODE_ENDLESS, 24'd1, 24'd1, 16'd0));
        send_item(make_item(MODE_COUNTED, 24'd1, 24'd1, 16'd3));
        // Ticks switch everything on, then end the short one-shots and blinks.
        repeat (12) send_item(make_item(CMD_TICK, 24'd0, 24'd0, 16'd0));
        // A new start must take the lowest slot that has been freed.
        send_item(make_item(MODE_ONESHOT, 24'd20, 24'd0, 16'd0));
        send_item(make_item(CMD_TICK, 24'd0, 24'd0, 16'd0));

        // Random part, one phase per tick period. The shortest nonzero period first.
        set_tick_period(10'd1);
        run_phase(300, 1'b0);

        // The longest period in normal use. This phase opens with the long
        // receiver hold-off while the sender offers items without gaps.
        set_tick_period(10'd1000);
        hold_requests = hold_requests + 1;
        run_phase(300, 1'b0);

        set_tick_period(CFG_W'($urandom_range(2, 999)));
        run_phase(300, 1'b0);

        // All register bits set. Full-width times and counts and endless blinks
        // are allowed from here on; slots they take are never freed again.
        set_tick_period('1);
        run_phase(300, 1'b1);

        // A zero tick period: no channel ever toggles or ends after switching on.
        set_tick_period('0);
        run_phase(150, 1'b1);

        // Drain: wait until every expected result is in, then give the block
        // time to show any result that should not be there.
        in_valid <= 1'b0;
        idle_mode = IDLE_NONE;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (2 * ITEM_CYCLES) @(negedge clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // If the run has not finished by this time limit, it is reported as a failure and stopped.
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
